FILE: design/inactivity_power_state_controller_defines.svh
// Assertion macros for the inactivity power-state controller.
`ifndef INACTIVITY_POWER_STATE_CONTROLLER_DEFINES_SVH
`define INACTIVITY_POWER_STATE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define IPSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipsc assertion failed");

// Next-cycle implication, checked outside reset.
`define IPSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipsc assertion failed");

`else

`define IPSC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IPSC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/ipsc_pkg.sv
// Types, codes and constants shared by the inactivity power-state controller.
`default_nettype none

package ipsc_pkg;

  localparam int IDLE_COUNT_BITS = 32;
  localparam int CMP_BITS = (IDLE_COUNT_BITS > 32) ? IDLE_COUNT_BITS : 32;

  localparam logic [31:0] DEF_IDLE_AFTER_MS       = 32'd15000;
  localparam logic [31:0] DEF_DIM_AFTER_MS        = 32'd30000;
  localparam logic [31:0] DEF_SLEEP_AFTER_MS      = 32'd45000;
  localparam logic [31:0] DEF_DEEP_SLEEP_AFTER_MS = 32'd180000;
  localparam logic [6:0]  DEF_ACTIVE_LEVEL        = 7'd100;
  localparam logic [6:0]  DEF_DIM_LEVEL           = 7'd15;
  localparam logic [15:0] DEF_RETRY_DELAY_MS      = 16'd5000;
  localparam logic [6:0]  MAX_LEVEL               = 7'd100;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_NOTE   = 2'd1,
    FUNC_INPUT  = 2'd2,
    FUNC_SUPPLY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_DIM    = 2'd2,
    MODE_SLEEP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REASON_BOOT         = 3'd0,
    REASON_INPUT        = 3'd1,
    REASON_TIMEOUT      = 3'd2,
    REASON_POWER_EVENT  = 3'd3,
    REASON_POWER_BUTTON = 3'd4
  } reason_t;

  typedef enum logic [2:0] {
    CFG_IDLE_AFTER       = 3'd0,
    CFG_DIM_AFTER        = 3'd1,
    CFG_SLEEP_AFTER      = 3'd2,
    CFG_DEEP_SLEEP_AFTER = 3'd3,
    CFG_ACTIVE_LEVEL     = 3'd4,
    CFG_DIM_LEVEL        = 3'd5,
    CFG_RETRY_DELAY      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] idle_after_ms;
    logic [31:0] dim_after_ms;
    logic [31:0] sleep_after_ms;
    logic [31:0] deep_sleep_after_ms;
    logic [6:0]  active_level;
    logic [6:0]  dim_level;
    logic [15:0] retry_delay_ms;
  } cfg_t;

  typedef struct packed {
    mode_t                      mode;
    reason_t                    reason;
    logic [IDLE_COUNT_BITS-1:0] idle_count;
    logic [15:0]                retry_left;
    logic                       supply_known;
    logic                       supply_present;
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] elapsed_ms;
    logic        touch_pending;
    logic [2:0]  wake_reason;
    logic        long_press_power;
    logic        ext_power;
  } in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  last_reason;
    logic [6:0]  brightness;
    logic [31:0] idle_time_ms;
    logic        changed;
    logic        deep_sleep_request;
    logic        power_off_request;
    logic        consumed;
  } out_t;

  function automatic logic [6:0] level_of(input mode_t m, input cfg_t c);
    logic [6:0] v;
    v = (m == MODE_DIM) ? c.dim_level : c.active_level;
    if (m == MODE_SLEEP) begin
      return '0;
    end
    return (v > MAX_LEVEL) ? MAX_LEVEL : v;
  endfunction

endpackage

`default_nettype wire

FILE: design/inactivity_power_state_controller.sv
// Top level of the inactivity power-state controller.
`default_nettype none
`include "inactivity_power_state_controller_defines.svh"

// Inactivity power-state controller: takes one item per cycle (tick, activity
// note, user input or supply event) while in_stall is low and returns exactly
// one result per item. An accepted item is held in the input register; the
// state update and result are computed from there and land in the output
// register, where the result is presented. Items flow at one per cycle while
// out_stall is low. While a result waits, the input register takes at most one
// more item and then stalls the input. Configuration writes are always
// ready and take effect on the next cycle; write them only while no item
// is in flight.
module inactivity_power_state_controller import ipsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  out_t   res;
  in_t    in_q;
  logic   in_q_valid;
  logic   advance;

  ipsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipsc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_q),
    .st_next (st_next),
    .res     (res)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;

  // Input register: hold while the output side is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  // Output register and state advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      st.mode           <= MODE_ACTIVE;
      st.reason         <= REASON_BOOT;
      st.idle_count     <= '0;
      st.retry_left     <= '0;
      st.supply_known   <= 1'b0;
      st.supply_present <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
      if (in_q_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_valid) begin
      out_item <= res;
    end
  end

  `IPSC_ASSERT_NXT(a_in_hold, clk, rst, in_q_valid && !advance, in_q_valid && $stable(in_q))
  `IPSC_ASSERT_IMP(a_ds_sleep, clk, rst, out_valid && out_item.deep_sleep_request,
                   out_item.mode == MODE_SLEEP && out_item.last_reason == REASON_TIMEOUT &&
                   !out_item.power_off_request)
  `IPSC_ASSERT_IMP(a_off_sleep, clk, rst, out_valid && out_item.power_off_request,
                   out_item.mode == MODE_SLEEP && out_item.consumed &&
                   out_item.last_reason == REASON_POWER_BUTTON)
  `IPSC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(out_item) && $stable(st))

endmodule

`default_nettype wire

FILE: design/ipsc_cfg_regs.sv
// Configuration register file with reset defaults.
`default_nettype none

module ipsc_cfg_regs import ipsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IDLE_AFTER:       cfg_next.idle_after_ms       = cfg_data;
        CFG_DIM_AFTER:        cfg_next.dim_after_ms        = cfg_data;
        CFG_SLEEP_AFTER:      cfg_next.sleep_after_ms      = cfg_data;
        CFG_DEEP_SLEEP_AFTER: cfg_next.deep_sleep_after_ms = cfg_data;
        CFG_ACTIVE_LEVEL:     cfg_next.active_level        = cfg_data[6:0];
        CFG_DIM_LEVEL:        cfg_next.dim_level           = cfg_data[6:0];
        CFG_RETRY_DELAY:      cfg_next.retry_delay_ms      = cfg_data[15:0];
        default:              cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_after_ms       <= DEF_IDLE_AFTER_MS;
      cfg.dim_after_ms        <= DEF_DIM_AFTER_MS;
      cfg.sleep_after_ms      <= DEF_SLEEP_AFTER_MS;
      cfg.deep_sleep_after_ms <= DEF_DEEP_SLEEP_AFTER_MS;
      cfg.active_level        <= DEF_ACTIVE_LEVEL;
      cfg.dim_level           <= DEF_DIM_LEVEL;
      cfg.retry_delay_ms      <= DEF_RETRY_DELAY_MS;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ipsc_step.sv
// Next-state and result logic for one item.
`default_nettype none

module ipsc_step import ipsc_pkg::*; (
  input  wire cfg_t   cfg,
  input  wire state_t st,
  input  wire in_t    item,
  output state_t      st_next,
  output out_t        res
);

  logic [IDLE_COUNT_BITS:0]   sum;
  logic [IDLE_COUNT_BITS-1:0] idle_tick;
  logic [15:0]                retry_tick;
  logic [CMP_BITS-1:0]        idle_ext;
  logic [CMP_BITS-1:0]        idle_out;
  logic                       allow;
  logic                       ds_req;
  logic                       off_req;
  logic                       consumed;
  reason_t                    note_reason;

  always_comb begin
    sum        = {1'b0, st.idle_count} + (IDLE_COUNT_BITS + 1)'(item.elapsed_ms);
    idle_tick  = sum[IDLE_COUNT_BITS] ? '1 : sum[IDLE_COUNT_BITS-1:0];
    retry_tick = (st.retry_left > item.elapsed_ms) ? (st.retry_left - item.elapsed_ms) : '0;
    idle_ext   = CMP_BITS'(idle_tick);
    allow      = !(st.supply_known && st.supply_present);
    ds_req     = 1'b0;
    off_req    = 1'b0;
    consumed   = 1'b0;

    if (item.wake_reason inside {[REASON_BOOT:REASON_POWER_BUTTON]}) begin
      note_reason = reason_t'(item.wake_reason);
    end else begin
      note_reason = REASON_BOOT;
    end

    st_next = st;

    case (func_t'(item.func))
      FUNC_TICK: begin
        st_next.idle_count = idle_tick;
        st_next.retry_left = retry_tick;
        if (st.mode != MODE_ACTIVE && item.touch_pending) begin
          // Touch wakes from any lowered state
          st_next.idle_count = '0;
          st_next.retry_left = '0;
          st_next.mode       = MODE_ACTIVE;
          st_next.reason     = REASON_INPUT;
        end else if (allow && idle_ext >= CMP_BITS'(cfg.deep_sleep_after_ms) &&
                     retry_tick == '0) begin
          st_next.mode       = MODE_SLEEP;
          st_next.reason     = REASON_TIMEOUT;
          st_next.retry_left = cfg.retry_delay_ms;
          ds_req             = 1'b1;
        end else if (idle_ext >= CMP_BITS'(cfg.sleep_after_ms) && st.mode != MODE_SLEEP) begin
          st_next.mode   = MODE_SLEEP;
          st_next.reason = REASON_TIMEOUT;
        end else if (idle_ext >= CMP_BITS'(cfg.dim_after_ms) && st.mode != MODE_DIM &&
                     st.mode != MODE_SLEEP) begin
          st_next.mode   = MODE_DIM;
          st_next.reason = REASON_TIMEOUT;
        end else if (idle_ext >= CMP_BITS'(cfg.idle_after_ms) && st.mode == MODE_ACTIVE) begin
          st_next.mode   = MODE_IDLE;
          st_next.reason = REASON_TIMEOUT;
        end
      end
      FUNC_NOTE: begin
        st_next.idle_count = '0;
        st_next.retry_left = '0;
        st_next.mode       = MODE_ACTIVE;
        st_next.reason     = note_reason;
      end
      FUNC_INPUT: begin
        consumed           = (st.mode == MODE_SLEEP);
        st_next.idle_count = '0;
        st_next.retry_left = '0;
        st_next.mode       = MODE_ACTIVE;
        st_next.reason     = REASON_INPUT;
        if (item.long_press_power) begin
          st_next.mode   = MODE_SLEEP;
          st_next.reason = REASON_POWER_BUTTON;
          off_req        = 1'b1;
          consumed       = 1'b1;
        end
      end
      default: begin
        // Supply event
        st_next.supply_known   = 1'b1;
        st_next.supply_present = item.ext_power;
        st_next.idle_count     = '0;
        st_next.retry_left     = '0;
        st_next.mode           = MODE_ACTIVE;
        st_next.reason         = REASON_POWER_EVENT;
      end
    endcase

    idle_out = CMP_BITS'(st_next.idle_count);

    res.mode               = st_next.mode;
    res.last_reason        = st_next.reason;
    res.brightness         = level_of(st_next.mode, cfg);
    res.idle_time_ms       = (idle_out > CMP_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                             idle_out[31:0];
    res.changed            = (st_next.mode != st.mode) || (st_next.reason != st.reason);
    res.deep_sleep_request = ds_req;
    res.power_off_request  = off_req;
    res.consumed           = consumed;
  end

endmodule

`default_nettype wire
